// File: rtl/knnra_pkg.sv
// shared types, widths and codes for the region association block
// no dependencies; every other file of the block but knnra_ram imports this package
package knnra_pkg;

   localparam int MAX_REGIONS = 64;
   localparam int MAX_RANK    = 15;
   localparam int IDX_W       = $clog2(MAX_REGIONS);
   localparam int CNT_W       = IDX_W + 1;
   localparam int TAB_AW      = 2 * IDX_W;
   localparam int TAB_DEPTH   = MAX_REGIONS * MAX_REGIONS;

   localparam int POS_W   = 16;
   localparam int AREA_W  = 20;
   localparam int ID_W    = 16;
   localparam int SQ_W    = 2 * POS_W;
   localparam int DIST_W  = SQ_W + 1;
   localparam int RANK_W  = 4;
   localparam int NCNT_W  = 4;
   localparam int RRANK_W = RANK_W + 1;
   localparam int MAXD_W  = 12;
   localparam int LIM_W   = 2 * MAXD_W;
   localparam int FRAC_W  = 8;
   localparam int RATIO_W = 17;
   localparam int ONE_W   = 16;
   localparam int PROD_W  = RATIO_W + AREA_W;
   localparam int TOTAL_W = 7;

   localparam logic [NCNT_W-1:0]  NCOUNT_RESET = NCNT_W'(3);
   localparam logic [MAXD_W-1:0]  MAXD_RESET   = MAXD_W'(20);
   localparam logic [RATIO_W-1:0] RATIO_RESET  = RATIO_W'(8192);

   typedef enum logic [1:0] {
      ACT_LOAD_PREV = 2'd0,
      ACT_LOAD_CURR = 2'd1,
      ACT_RUN       = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      CSR_NEIGHBOUR_COUNT = 2'd0,
      CSR_MAX_DISTANCE    = 2'd1,
      CSR_MIN_AREA_RATIO  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [1:0]        action;
      logic [POS_W-1:0]  x_pos;
      logic [POS_W-1:0]  y_pos;
      logic [AREA_W-1:0] area;
      logic [ID_W-1:0]   region_id;
   } req_type;

   typedef struct packed {
      logic [5:0]         region_index;
      logic [ID_W-1:0]    next_id;
      logic               matched;
      logic [TOTAL_W-1:0] assoc_count;
      logic               overflow;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic [POS_W-1:0]  x_pos;
      logic [POS_W-1:0]  y_pos;
      logic [AREA_W-1:0] area;
   } prev_entry_type;

   typedef struct packed {
      logic [POS_W-1:0]  x_pos;
      logic [POS_W-1:0]  y_pos;
      logic [AREA_W-1:0] area;
      logic [ID_W-1:0]   region_id;
   } curr_entry_type;

   typedef struct packed {
      logic [RANK_W-1:0] rank;
      logic [RANK_W-1:0] closer;
      logic [DIST_W-1:0] distance;
   } tab_entry_type;

   typedef struct packed {
      logic            hit;
      logic [ID_W-1:0] next_id;
   } res_entry_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_D_ADDR, ST_D_MUL, ST_D_SUM, ST_D_WRITE,
      ST_C_ADDR, ST_C_HOLD, ST_C_L_ADDR, ST_C_L_CMP, ST_C_WRITE,
      ST_R_ADDR, ST_R_CHECK,
      ST_A_ROW, ST_S_ADDR, ST_S_CHECK,
      ST_L_ADDR, ST_L_READ, ST_L_MUL, ST_L_DECIDE,
      ST_E_ADDR, ST_E_OUT,
      ST_FINISH
   } state_type;

endpackage

// File: rtl/knnra_ram.sv
// generic single write, single read memory with registered read data
// no dependencies
module knnra_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/knnra_dist_unit.sv
// squared centroid distance of two regions, two register stages
// depends on knnra_pkg
module knnra_dist_unit
   import knnra_pkg::*;
(
   input  logic              clock,
   input  logic [POS_W-1:0]  ax,
   input  logic [POS_W-1:0]  ay,
   input  logic [POS_W-1:0]  bx,
   input  logic [POS_W-1:0]  by,
   output logic [DIST_W-1:0] sq_sum
);

   logic [POS_W-1:0]  dx, dy;
   logic [SQ_W-1:0]   sqx_in, sqx_ff, sqy_in, sqy_ff;
   logic [DIST_W-1:0] dist_in, dist_ff;

   always_comb begin
      dx      = (ax >= bx) ? (ax - bx) : (bx - ax);
      dy      = (ay >= by) ? (ay - by) : (by - ay);
      sqx_in  = SQ_W'(dx) * SQ_W'(dx);
      sqy_in  = SQ_W'(dy) * SQ_W'(dy);
      dist_in = DIST_W'(sqx_ff) + DIST_W'(sqy_ff);
   end

   always_ff @(posedge clock) begin
      sqx_ff  <= sqx_in;
      sqy_ff  <= sqy_in;
      dist_ff <= dist_in;
   end

   assign sq_sum = dist_ff;

endmodule

// File: rtl/knnra_area_unit.sv
// area ratio test by cross multiplication, two register stages
// depends on knnra_pkg
module knnra_area_unit
   import knnra_pkg::*;
(
   input  logic               clock,
   input  logic [AREA_W-1:0]  area_a,
   input  logic [AREA_W-1:0]  area_b,
   input  logic [RATIO_W-1:0] ratio,
   output logic               area_ok
);

   logic [AREA_W-1:0] small_in, small_ff, large_in, large_ff;
   logic [PROD_W-1:0] prod_in, prod_ff;
   logic              ok_in, ok_ff;

   always_comb begin
      small_in = (area_a < area_b) ? area_a : area_b;
      large_in = (area_a < area_b) ? area_b : area_a;
      prod_in  = PROD_W'(ratio) * PROD_W'(large_in);
      // both areas zero never passes
      ok_in    = (large_ff != '0) &&
                 (PROD_W'({small_ff, {ONE_W{1'b0}}}) >= prod_ff);
   end

   always_ff @(posedge clock) begin
      small_ff <= small_in;
      large_ff <= large_in;
      prod_ff  <= prod_in;
      ok_ff    <= ok_in;
   end

   assign area_ok = ok_ff;

endmodule

// File: rtl/knn_region_association_top.sv
// top level of the k-nearest-neighbour region association block
// depends on knnra_pkg, knnra_ram, knnra_dist_unit, knnra_area_unit
//
// regions are loaded one item per cycle while idle (action 0 previous frame, action 1
// current frame, up to 64 of each; further loads are dropped and flagged).
// a run item (action 2) keeps busy high until every result has gone out.
// a run goes through distances, closer-neighbour counts, a rank pass, the association
// and then the results. results come out one at a time, each on rsp_valid for exactly
// one cycle, and cannot be held off by the receiver. the table memory needs no
// clearing pass: each run rewrites every entry it reads.
// configuration writes are always taken, but must only be made while idle.
module knn_region_association_top
   import knnra_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  req_type            req_data,
   output logic               rsp_valid,
   output rsp_type            rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [RATIO_W-1:0] csr_wdata
);

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    prev_loaded_ff, prev_loaded_in;
   logic [CNT_W-1:0]    curr_loaded_ff, curr_loaded_in;
   logic                dropped_ff, dropped_in;
   logic [NCNT_W-1:0]   ncount_ff, ncount_in;
   logic [MAXD_W-1:0]   maxd_ff, maxd_in;
   logic [RATIO_W-1:0]  ratio_ff, ratio_in;
   logic [LIM_W-1:0]    lim_ff, lim_in;
   logic [CNT_W-1:0]    i_ff, i_in, j_ff, j_in, l_ff, l_in;
   logic [RRANK_W-1:0]  r_ff, r_in;
   logic [RANK_W-1:0]   closer_ff, closer_in;
   logic [DIST_W-1:0]   dref_ff, dref_in;
   logic                own_ff, own_in;
   logic                hit_ff, hit_in;
   logic [ID_W-1:0]     id_ff, id_in;
   logic [TOTAL_W-1:0]  total_ff, total_in;
   logic [MAX_REGIONS-1:0] taken_ff, taken_in;

   // memory ports
   logic                prev_we, curr_we, tab_we, res_we;
   logic [IDX_W-1:0]    prev_wa, curr_wa, prev_ra;
   prev_entry_type      prev_wd, prev_rd;
   curr_entry_type      curr_wd, curr_rd;
   logic [TAB_AW-1:0]   tab_wa, tab_ra;
   tab_entry_type       tab_wd, tab_rd;
   res_entry_type       res_wd, res_rd;

   logic [DIST_W-1:0]   sq_dist;
   logic                area_ok;

   knnra_ram #(.WIDTH($bits(prev_entry_type)), .DEPTH(MAX_REGIONS)) u_prev_ram (
      .clock(clock), .wr_en(prev_we), .wr_addr(prev_wa), .wr_data(prev_wd),
      .rd_addr(prev_ra), .rd_data(prev_rd)
   );

   knnra_ram #(.WIDTH($bits(curr_entry_type)), .DEPTH(MAX_REGIONS)) u_curr_ram (
      .clock(clock), .wr_en(curr_we), .wr_addr(curr_wa), .wr_data(curr_wd),
      .rd_addr(j_ff[IDX_W-1:0]), .rd_data(curr_rd)
   );

   // distance, closer-neighbour count and rank per (previous, current) pair
   knnra_ram #(.WIDTH($bits(tab_entry_type)), .DEPTH(TAB_DEPTH)) u_tab_ram (
      .clock(clock), .wr_en(tab_we), .wr_addr(tab_wa), .wr_data(tab_wd),
      .rd_addr(tab_ra), .rd_data(tab_rd)
   );

   // per previous region outcome, held until all associations are known
   knnra_ram #(.WIDTH($bits(res_entry_type)), .DEPTH(MAX_REGIONS)) u_res_ram (
      .clock(clock), .wr_en(res_we), .wr_addr(i_ff[IDX_W-1:0]), .wr_data(res_wd),
      .rd_addr(i_ff[IDX_W-1:0]), .rd_data(res_rd)
   );

   knnra_dist_unit u_dist (
      .clock(clock),
      .ax(prev_rd.x_pos), .ay(prev_rd.y_pos),
      .bx(curr_rd.x_pos), .by(curr_rd.y_pos),
      .sq_sum(sq_dist)
   );

   knnra_area_unit u_area (
      .clock(clock),
      .area_a(prev_rd.area), .area_b(curr_rd.area),
      .ratio(ratio_ff), .area_ok(area_ok)
   );

   assign csr_ready = 1'b1;
   assign busy      = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         prev_loaded_ff <= '0;
         curr_loaded_ff <= '0;
         dropped_ff     <= 1'b0;
         ncount_ff      <= NCOUNT_RESET;
         maxd_ff        <= MAXD_RESET;
         ratio_ff       <= RATIO_RESET;
         taken_ff       <= '0;
         total_ff       <= '0;
      end else begin
         state_ff       <= state_in;
         prev_loaded_ff <= prev_loaded_in;
         curr_loaded_ff <= curr_loaded_in;
         dropped_ff     <= dropped_in;
         ncount_ff      <= ncount_in;
         maxd_ff        <= maxd_in;
         ratio_ff       <= ratio_in;
         taken_ff       <= taken_in;
         total_ff       <= total_in;
      end
      lim_ff    <= lim_in;
      i_ff      <= i_in;
      j_ff      <= j_in;
      l_ff      <= l_in;
      r_ff      <= r_in;
      closer_ff <= closer_in;
      dref_ff   <= dref_in;
      own_ff    <= own_in;
      hit_ff    <= hit_in;
      id_ff     <= id_in;
   end

   always_comb begin
      logic last_i, last_j, last_l, last_pl;
      logic [DIST_W-1:0] lim_q, floor_d;

      state_in       = state_ff;
      prev_loaded_in = prev_loaded_ff;
      curr_loaded_in = curr_loaded_ff;
      dropped_in     = dropped_ff;
      ncount_in      = ncount_ff;
      maxd_in        = maxd_ff;
      ratio_in       = ratio_ff;
      i_in           = i_ff;
      j_in           = j_ff;
      l_in           = l_ff;
      r_in           = r_ff;
      closer_in      = closer_ff;
      dref_in        = dref_ff;
      own_in         = own_ff;
      hit_in         = hit_ff;
      id_in          = id_ff;
      total_in       = total_ff;
      taken_in       = taken_ff;

      // limit squared, whole pixels to q.8
      lim_in  = LIM_W'(maxd_ff) * LIM_W'(maxd_ff);
      lim_q   = {1'b0, lim_ff, {FRAC_W{1'b0}}};
      floor_d = {dref_ff[DIST_W-1:FRAC_W], {FRAC_W{1'b0}}};

      last_i  = ((i_ff + CNT_W'(1)) == prev_loaded_ff);
      last_j  = ((j_ff + CNT_W'(1)) == curr_loaded_ff);
      last_l  = ((l_ff + CNT_W'(1)) == curr_loaded_ff);
      last_pl = ((l_ff + CNT_W'(1)) == prev_loaded_ff);

      prev_we = 1'b0;
      curr_we = 1'b0;
      prev_wa = prev_loaded_ff[IDX_W-1:0];
      curr_wa = curr_loaded_ff[IDX_W-1:0];
      prev_wd = '{x_pos: req_data.x_pos, y_pos: req_data.y_pos, area: req_data.area};
      curr_wd = '{x_pos: req_data.x_pos, y_pos: req_data.y_pos, area: req_data.area,
                  region_id: req_data.region_id};
      prev_ra = (state_ff == ST_L_ADDR && !own_ff) ? l_ff[IDX_W-1:0] : i_ff[IDX_W-1:0];

      tab_we = 1'b0;
      tab_wa = {i_ff[IDX_W-1:0], j_ff[IDX_W-1:0]};
      tab_wd = '{rank: '0, closer: closer_ff, distance: dref_ff};
      case (state_ff)
         ST_C_L_ADDR: tab_ra = {i_ff[IDX_W-1:0], l_ff[IDX_W-1:0]};
         ST_L_ADDR:   tab_ra = {l_ff[IDX_W-1:0], j_ff[IDX_W-1:0]};
         default:     tab_ra = {i_ff[IDX_W-1:0], j_ff[IDX_W-1:0]};
      endcase

      res_we = 1'b0;
      res_wd = '{hit: 1'b0, next_id: '0};

      rsp_valid = 1'b0;
      rsp_data  = '{region_index: 6'(i_ff), next_id: res_rd.next_id,
                    matched: res_rd.hit, assoc_count: total_ff,
                    overflow: dropped_ff, last: last_i};

      if (csr_valid) begin
         case (csr_index)
            CSR_NEIGHBOUR_COUNT: ncount_in = csr_wdata[NCNT_W-1:0];
            CSR_MAX_DISTANCE:    maxd_in   = csr_wdata[MAXD_W-1:0];
            CSR_MIN_AREA_RATIO:  ratio_in  = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_data.action)
                  ACT_LOAD_PREV: begin
                     if (prev_loaded_ff == CNT_W'(MAX_REGIONS)) begin
                        dropped_in = 1'b1;
                     end else begin
                        prev_we        = 1'b1;
                        prev_loaded_in = prev_loaded_ff + CNT_W'(1);
                     end
                  end
                  ACT_LOAD_CURR: begin
                     if (curr_loaded_ff == CNT_W'(MAX_REGIONS)) begin
                        dropped_in = 1'b1;
                     end else begin
                        curr_we        = 1'b1;
                        curr_loaded_in = curr_loaded_ff + CNT_W'(1);
                     end
                  end
                  ACT_RUN: begin
                     taken_in = '0;
                     total_in = '0;
                     i_in     = '0;
                     j_in     = '0;
                     r_in     = RRANK_W'(1);
                     if (prev_loaded_ff == '0) begin
                        state_in = ST_FINISH;
                     end else if (curr_loaded_ff == '0) begin
                        state_in = ST_A_ROW;
                     end else begin
                        state_in = ST_D_ADDR;
                     end
                  end
                  default: ;
               endcase
            end
         end

         // distance of every pair
         ST_D_ADDR: state_in = ST_D_MUL;
         ST_D_MUL:  state_in = ST_D_SUM;
         ST_D_SUM:  state_in = ST_D_WRITE;
         ST_D_WRITE: begin
            tab_we   = 1'b1;
            tab_wd   = '{rank: '0, closer: '0, distance: sq_dist};
            state_in = ST_D_ADDR;
            if (last_j) begin
               j_in = '0;
               if (last_i) begin
                  i_in     = '0;
                  state_in = ST_C_ADDR;
               end else begin
                  i_in = i_ff + CNT_W'(1);
               end
            end else begin
               j_in = j_ff + CNT_W'(1);
            end
         end

         // count row entries closer than the whole-pixel floor, saturating
         ST_C_ADDR: state_in = ST_C_HOLD;
         ST_C_HOLD: begin
            dref_in   = tab_rd.distance;
            closer_in = '0;
            l_in      = '0;
            state_in  = ST_C_L_ADDR;
         end
         ST_C_L_ADDR: state_in = ST_C_L_CMP;
         ST_C_L_CMP: begin
            if (tab_rd.distance < floor_d && closer_ff != '1) begin
               closer_in = closer_ff + RANK_W'(1);
            end
            if (last_l) begin
               state_in = ST_C_WRITE;
            end else begin
               l_in     = l_ff + CNT_W'(1);
               state_in = ST_C_L_ADDR;
            end
         end
         ST_C_WRITE: begin
            tab_we   = 1'b1;
            state_in = ST_C_ADDR;
            if (last_j) begin
               j_in = '0;
               if (last_i) begin
                  i_in = '0;
                  r_in = RRANK_W'(1);
                  state_in = (ncount_ff == '0) ? ST_A_ROW : ST_R_ADDR;
               end else begin
                  i_in = i_ff + CNT_W'(1);
               end
            end else begin
               j_in = j_ff + CNT_W'(1);
            end
         end

         // rank pass: first free, in-limit entry of the row with fewer closer entries than the rank, per rank
         ST_R_ADDR: state_in = ST_R_CHECK;
         ST_R_CHECK: begin
            logic take, row_end;
            take    = (tab_rd.rank == '0) && (tab_rd.distance < lim_q) &&
                      ({1'b0, tab_rd.closer} < r_ff);
            row_end = take || last_j;
            state_in = ST_R_ADDR;
            if (take) begin
               tab_we = 1'b1;
               tab_wd = '{rank: r_ff[RANK_W-1:0], closer: tab_rd.closer,
                          distance: tab_rd.distance};
            end
            if (row_end) begin
               j_in = '0;
               if (last_i) begin
                  i_in = '0;
                  if (r_ff == {1'b0, ncount_ff}) begin
                     state_in = ST_A_ROW;
                  end else begin
                     r_in = r_ff + RRANK_W'(1);
                  end
               end else begin
                  i_in = i_ff + CNT_W'(1);
               end
            end else begin
               j_in = j_ff + CNT_W'(1);
            end
         end

         // greedy association, one previous region per row
         ST_A_ROW: begin
            r_in = RRANK_W'(1);
            j_in = '0;
            if (curr_loaded_ff == '0) begin
               res_we   = 1'b1;
               state_in = last_i ? ST_E_ADDR : ST_A_ROW;
               i_in     = last_i ? '0 : i_ff + CNT_W'(1);
            end else begin
               state_in = ST_S_ADDR;
            end
         end
         ST_S_ADDR: state_in = ST_S_CHECK;
         ST_S_CHECK: begin
            if (!taken_ff[j_ff[IDX_W-1:0]] && ({1'b0, tab_rd.rank} == r_ff)) begin
               dref_in  = tab_rd.distance;
               l_in     = i_ff + CNT_W'(1);
               own_in   = last_i;
               state_in = ST_L_ADDR;
            end else if (last_j) begin
               // no candidate at this rank: unmatched
               res_we   = 1'b1;
               state_in = last_i ? ST_E_ADDR : ST_A_ROW;
               i_in     = last_i ? '0 : i_ff + CNT_W'(1);
            end else begin
               j_in     = j_ff + CNT_W'(1);
               state_in = ST_S_ADDR;
            end
         end
         ST_L_ADDR: state_in = ST_L_READ;
         ST_L_READ: begin
            hit_in   = ({1'b0, tab_rd.rank} == r_ff) && (tab_rd.distance < dref_ff);
            id_in    = curr_rd.region_id;
            state_in = ST_L_MUL;
         end
         ST_L_MUL: state_in = ST_L_DECIDE;
         ST_L_DECIDE: begin
            logic retry;
            retry = own_ff ? !area_ok : (hit_ff && area_ok);
            if (own_ff && area_ok) begin
               res_we   = 1'b1;
               res_wd   = '{hit: 1'b1, next_id: id_ff};
               taken_in = taken_ff | (MAX_REGIONS'(1) << j_ff[IDX_W-1:0]);
               total_in = total_ff + TOTAL_W'(1);
               state_in = last_i ? ST_E_ADDR : ST_A_ROW;
               i_in     = last_i ? '0 : i_ff + CNT_W'(1);
            end else if (retry) begin
               if (r_ff == RRANK_W'(MAX_RANK)) begin
                  res_we   = 1'b1;
                  state_in = last_i ? ST_E_ADDR : ST_A_ROW;
                  i_in     = last_i ? '0 : i_ff + CNT_W'(1);
               end else begin
                  r_in     = r_ff + RRANK_W'(1);
                  j_in     = '0;
                  state_in = ST_S_ADDR;
               end
            end else begin
               // later region not in the way: look further down
               own_in   = last_pl;
               l_in     = l_ff + CNT_W'(1);
               state_in = ST_L_ADDR;
            end
         end

         // results in load order
         ST_E_ADDR: state_in = ST_E_OUT;
         ST_E_OUT: begin
            rsp_valid = 1'b1;
            if (last_i) begin
               state_in = ST_FINISH;
            end else begin
               i_in     = i_ff + CNT_W'(1);
               state_in = ST_E_ADDR;
            end
         end

         ST_FINISH: begin
            prev_loaded_in = '0;
            curr_loaded_in = '0;
            dropped_in     = 1'b0;
            state_in       = ST_IDLE;
         end

         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// File: dv/knn_region_association_checker.sv
// checker for the region association block: watches the request, result and csr channels,
// keeps its own copy of the region stores and registers and compares every result item
// depends on knnra_pkg
`timescale 1ns / 100ps

module knn_region_association_checker
   import knnra_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  req_type            req_data,
   input  logic               rsp_valid,
   input  rsp_type            rsp_data,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [RATIO_W-1:0] csr_wdata,
   output int                 error_count,
   output int                 outstanding,
   output int                 results_checked,
   output int                 runs_seen
);

   logic [POS_W-1:0]   prev_x    [MAX_REGIONS];
   logic [POS_W-1:0]   prev_y    [MAX_REGIONS];
   logic [AREA_W-1:0]  prev_area [MAX_REGIONS];
   logic [POS_W-1:0]   curr_x    [MAX_REGIONS];
   logic [POS_W-1:0]   curr_y    [MAX_REGIONS];
   logic [AREA_W-1:0]  curr_area [MAX_REGIONS];
   logic [ID_W-1:0]    curr_id   [MAX_REGIONS];
   int                 prev_count;
   int                 curr_count;
   logic               dropped;
   logic [NCNT_W-1:0]  k_reg;
   logic [MAXD_W-1:0]  maxd_reg;
   logic [RATIO_W-1:0] ratio_reg;

   rsp_type expected_assoc[$];

   assign outstanding = expected_assoc.size();

   function automatic bit areas_compatible(logic [AREA_W-1:0] a, logic [AREA_W-1:0] b);
      longint unsigned smaller, larger;
      smaller = (a < b) ? a : b;
      larger  = (a < b) ? b : a;
      if (larger == 0) return 1'b0;
      return (smaller * 65536) >= (longint'(ratio_reg) * larger);
   endfunction

   function automatic longint unsigned centre_gap(int i, int j);
      longint unsigned dx, dy;
      dx = (prev_x[i] >= curr_x[j]) ? prev_x[i] - curr_x[j] : curr_x[j] - prev_x[i];
      dy = (prev_y[i] >= curr_y[j]) ? prev_y[i] - curr_y[j] : curr_y[j] - prev_y[i];
      return dx * dx + dy * dy;
   endfunction

   // whole matching pass for the regions held, pushes one item per previous region
   function automatic void predict_associations();
      longint unsigned gap_tab [MAX_REGIONS][MAX_REGIONS];
      int              rank [MAX_REGIONS][MAX_REGIONS];
      bit              taken [MAX_REGIONS];
      logic [ID_W-1:0] next_id [MAX_REGIONS];
      bit              hit [MAX_REGIONS];
      longint unsigned lim, floor_d, dij;
      int              kk, cnt, r, total;
      bit              done, retry;
      rsp_type         res;
      lim = (longint'(maxd_reg) * maxd_reg) << 8;
      kk  = (k_reg > MAX_RANK) ? MAX_RANK : k_reg;
      total = 0;
      for (int i = 0; i < MAX_REGIONS; i++) begin
         taken[i] = 0;
         for (int j = 0; j < MAX_REGIONS; j++) rank[i][j] = 0;
      end
      for (int i = 0; i < prev_count; i++)
         for (int j = 0; j < curr_count; j++) gap_tab[i][j] = centre_gap(i, j);

      for (int rk = 1; rk <= kk; rk++) begin
         for (int i = 0; i < prev_count; i++) begin
            for (int j = 0; j < curr_count; j++) begin
               if (rank[i][j] != 0 || gap_tab[i][j] >= lim) continue;
               floor_d = (gap_tab[i][j] >> 8) << 8;
               cnt = 0;
               for (int l = 0; l < curr_count; l++)
                  if (gap_tab[i][l] < floor_d) cnt++;
               if (cnt < rk) begin
                  rank[i][j] = rk;
                  break;
               end
            end
         end
      end

      // greedy take, stepping to the next rank when a later region has a better claim or the area test fails
      for (int i = 0; i < prev_count; i++) begin
         r = 1;
         done = 0;
         next_id[i] = '0;
         hit[i] = 0;
         while (!done && r <= MAX_RANK) begin
            retry = 0;
            for (int j = 0; j < curr_count; j++) begin
               if (taken[j] || rank[i][j] != r) continue;
               dij = gap_tab[i][j];
               for (int l = i + 1; l < prev_count; l++) begin
                  if (rank[l][j] == r && gap_tab[l][j] < dij &&
                      areas_compatible(prev_area[l], curr_area[j])) begin
                     retry = 1;
                     break;
                  end
               end
               if (retry) break;
               if (areas_compatible(prev_area[i], curr_area[j])) begin
                  next_id[i] = curr_id[j];
                  hit[i] = 1;
                  taken[j] = 1;
                  total++;
                  done = 1;
               end else begin
                  retry = 1;
               end
               break;
            end
            if (retry) r++;
            else done = 1;
         end
      end

      for (int i = 0; i < prev_count; i++) begin
         res.region_index = 6'(i);
         res.next_id      = next_id[i];
         res.matched      = hit[i];
         res.assoc_count  = TOTAL_W'(total);
         res.overflow     = dropped;
         res.last         = (i + 1 == prev_count);
         expected_assoc.push_back(res);
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         prev_count      <= 0;
         curr_count      <= 0;
         dropped         <= 1'b0;
         k_reg           <= NCOUNT_RESET;
         maxd_reg        <= MAXD_RESET;
         ratio_reg       <= RATIO_RESET;
         error_count     <= 0;
         results_checked <= 0;
         runs_seen       <= 0;
         expected_assoc.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_NEIGHBOUR_COUNT: k_reg <= csr_wdata[NCNT_W-1:0];
               CSR_MAX_DISTANCE:    maxd_reg <= csr_wdata[MAXD_W-1:0];
               CSR_MIN_AREA_RATIO:  ratio_reg <= csr_wdata;
               default: ;
            endcase
         end
         if (start && !busy) begin
            if (req_data.action == ACT_LOAD_PREV) begin
               if (prev_count >= MAX_REGIONS) dropped <= 1'b1;
               else begin
                  prev_x[prev_count]    <= req_data.x_pos;
                  prev_y[prev_count]    <= req_data.y_pos;
                  prev_area[prev_count] <= req_data.area;
                  prev_count <= prev_count + 1;
               end
            end else if (req_data.action == ACT_LOAD_CURR) begin
               if (curr_count >= MAX_REGIONS) dropped <= 1'b1;
               else begin
                  curr_x[curr_count]    <= req_data.x_pos;
                  curr_y[curr_count]    <= req_data.y_pos;
                  curr_area[curr_count] <= req_data.area;
                  curr_id[curr_count]   <= req_data.region_id;
                  curr_count <= curr_count + 1;
               end
            end else if (req_data.action == ACT_RUN) begin
               predict_associations();
               runs_seen  <= runs_seen + 1;
               prev_count <= 0;
               curr_count <= 0;
               dropped    <= 1'b0;
            end
         end
         if (rsp_valid) begin
            if (expected_assoc.size() == 0) begin
               $error("result item with nothing expected: %p", rsp_data);
               error_count <= error_count + 1;
            end else begin
               want = expected_assoc.pop_front();
               results_checked <= results_checked + 1;
               if (rsp_data !== want) begin
                  error_count <= error_count + 1;
                  if (rsp_data.region_index !== want.region_index)
                     $error("region_index expected %0d got %0d",
                            want.region_index, rsp_data.region_index);
                  if (rsp_data.next_id !== want.next_id)
                     $error("next_id expected %0d got %0d", want.next_id, rsp_data.next_id);
                  if (rsp_data.matched !== want.matched)
                     $error("matched expected %0d got %0d", want.matched, rsp_data.matched);
                  if (rsp_data.assoc_count !== want.assoc_count)
                     $error("assoc_count expected %0d got %0d",
                            want.assoc_count, rsp_data.assoc_count);
                  if (rsp_data.overflow !== want.overflow)
                     $error("overflow expected %0d got %0d", want.overflow, rsp_data.overflow);
                  if (rsp_data.last !== want.last)
                     $error("last expected %0d got %0d", want.last, rsp_data.last);
               end
            end
         end
      end
   end

endmodule

// File: dv/knn_region_association_top_tb.sv
// top of the region association testbench: clock, reset, stimulus and verdict
// depends on knnra_pkg, knn_region_association_top and knn_region_association_checker
`timescale 1ns / 100ps

module knn_region_association_top_tb;
   import knnra_pkg::*;

   localparam logic [1:0] ACT_SPARE = 2'd3;   // unused action code, block ignores it
   localparam int IDLE_LIMIT = 400000;         // cycles with no handshake at all
   localparam int ITEM_TARGET = 320;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start;
   logic               busy;
   req_type            req_data;
   logic               rsp_valid;
   rsp_type            rsp_data;
   logic               csr_valid;
   logic               csr_ready;
   logic [1:0]         csr_index;
   logic [RATIO_W-1:0] csr_wdata;

   int error_count, outstanding, results_checked, runs_seen;
   int items_sent;
   int idle_cycles;
   int burst_left;
   logic [MAXD_W-1:0] cur_maxd;

   knn_region_association_top u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   knn_region_association_checker u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .error_count(error_count), .outstanding(outstanding),
      .results_checked(results_checked), .runs_seen(runs_seen)
   );

   always #5 clock = ~clock;

   // watchdog: any handshake on any channel counts as progress
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("knn_region_association_top_tb: errors");
            $finish;
         end
      end
   end

   // offers one item and holds it until taken, then maybe leaves a gap
   task automatic send_item(logic [1:0] act, logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                            logic [AREA_W-1:0] area, logic [ID_W-1:0] id);
      int gap;
      start              <= 1'b1;
      req_data.action    <= act;
      req_data.x_pos     <= x;
      req_data.y_pos     <= y;
      req_data.area      <= area;
      req_data.region_id <= id;
      do @(posedge clock); while (busy);
      if (act != ACT_SPARE) items_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 12);
         // now and then a long stretch with no gaps at all
         if ($urandom_range(0, 7) == 0) burst_left = 40;
         gap = $urandom_range(1, 6);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // drops start and lets every outstanding result item drain
   task automatic wait_idle();
      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0 || busy) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [RATIO_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_MAX_DISTANCE) cur_maxd = value[MAXD_W-1:0];
      @(posedge clock);
   endtask

   function automatic logic [POS_W-1:0] near_pos(logic [POS_W-1:0] base);
      int unsigned spread, p;
      if ($urandom_range(0, 9) == 0) return POS_W'($urandom_range(0, 65535));
      spread = cur_maxd * 16 + 8;
      p = base + $urandom_range(0, spread);
      return (p > 65535) ? 16'hFFFF : p[POS_W-1:0];
   endfunction

   function automatic logic [AREA_W-1:0] near_area(logic [AREA_W-1:0] base);
      longint unsigned a;
      case ($urandom_range(0, 15))
         0:       return '0;
         1:       return AREA_W'($urandom_range(0, 1048575));
         default: begin
            a = longint'(base) * $urandom_range(20, 100) / 100;
            return a[AREA_W-1:0];
         end
      endcase
   endfunction

   // one frame pair with a run at the end; loads of both frames interleave at random
   task automatic random_session();
      int np, nc;
      logic [POS_W-1:0]  bx, by;
      logic [AREA_W-1:0] ba;
      np = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 10) : $urandom_range(0, 6);
      nc = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 10) : $urandom_range(0, 6);
      bx = POS_W'($urandom_range(0, 65535));
      by = POS_W'($urandom_range(0, 65535));
      ba = AREA_W'($urandom_range(1, 1048575));
      while (np > 0 || nc > 0) begin
         if ($urandom_range(0, 19) == 0)
            send_item(ACT_SPARE, POS_W'($urandom), POS_W'($urandom), AREA_W'($urandom),
                      ID_W'($urandom));
         if (nc == 0 || (np > 0 && $urandom_range(0, 1) == 0)) begin
            send_item(ACT_LOAD_PREV, near_pos(bx), near_pos(by), near_area(ba),
                      ID_W'($urandom));
            np--;
         end else begin
            send_item(ACT_LOAD_CURR, near_pos(bx), near_pos(by), near_area(ba),
                      ($urandom_range(0, 15) == 0) ? 16'd0 : 16'($urandom));
            nc--;
         end
      end
      send_item(ACT_RUN, POS_W'($urandom), POS_W'($urandom), AREA_W'($urandom),
                ID_W'($urandom));
   endtask

   task automatic random_config();
      case ($urandom_range(0, 2))
         0: write_reg(CSR_NEIGHBOUR_COUNT, RATIO_W'($urandom_range(0, 15)));
         1: case ($urandom_range(0, 5))
               0:       write_reg(CSR_MAX_DISTANCE, 17'd0);
               1:       write_reg(CSR_MAX_DISTANCE, 17'd4095);
               default: write_reg(CSR_MAX_DISTANCE, RATIO_W'($urandom_range(1, 300)));
            endcase
         default: case ($urandom_range(0, 7))
               0:       write_reg(CSR_MIN_AREA_RATIO, 17'd0);
               1:       write_reg(CSR_MIN_AREA_RATIO, 17'd65536);
               2:       write_reg(CSR_MIN_AREA_RATIO, 17'd131071);
               default: write_reg(CSR_MIN_AREA_RATIO, RATIO_W'($urandom_range(0, 65536)));
            endcase
      endcase
   endtask

   initial begin
      start      = 1'b0;
      req_data   = '0;
      csr_valid  = 1'b0;
      csr_index  = CSR_NEIGHBOUR_COUNT;
      csr_wdata  = '0;
      items_sent = 0;
      burst_left = 0;
      cur_maxd   = MAXD_RESET;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: corner positions, extreme areas and ids, a zero id match
      send_item(ACT_LOAD_PREV, 16'd0, 16'd0, 20'd100, 16'd1);
      send_item(ACT_LOAD_PREV, 16'hFFFF, 16'hFFFF, 20'hFFFFF, 16'hFFFF);
      send_item(ACT_LOAD_PREV, 16'd800, 16'd800, 20'd0, 16'd7);
      send_item(ACT_LOAD_CURR, 16'd16, 16'd0, 20'd90, 16'd0);
      send_item(ACT_LOAD_CURR, 16'hFFF0, 16'hFFFF, 20'hFFFFF, 16'hFFFF);
      send_item(ACT_LOAD_CURR, 16'd800, 16'd808, 20'd0, 16'd9);
      send_item(ACT_SPARE, 16'hFFFF, 16'hFFFF, 20'hFFFFF, 16'hFFFF);
      send_item(ACT_RUN, 16'd0, 16'd0, 20'd0, 16'd0);
      // run with an empty previous frame gives nothing back
      send_item(ACT_LOAD_CURR, 16'd5, 16'd5, 20'd5, 16'd5);
      send_item(ACT_RUN, 16'd0, 16'd0, 20'd0, 16'd0);
      wait_idle();

      // zero k: nothing ranked; widest limit and an open ratio test
      write_reg(CSR_NEIGHBOUR_COUNT, 17'd0);
      write_reg(CSR_MAX_DISTANCE, 17'd4095);
      write_reg(CSR_MIN_AREA_RATIO, 17'd0);
      send_item(ACT_LOAD_PREV, 16'd100, 16'd100, 20'd10, 16'd1);
      send_item(ACT_LOAD_CURR, 16'd110, 16'd100, 20'd1000, 16'd2);
      send_item(ACT_RUN, 16'd0, 16'd0, 20'd0, 16'd0);
      wait_idle();
      write_reg(CSR_NEIGHBOUR_COUNT, 17'd15);
      send_item(ACT_LOAD_PREV, 16'd100, 16'd100, 20'd10, 16'd1);
      send_item(ACT_LOAD_PREV, 16'd104, 16'd100, 20'd1000, 16'd3);
      send_item(ACT_LOAD_CURR, 16'd110, 16'd100, 20'd1000, 16'd2);
      send_item(ACT_LOAD_CURR, 16'hFFFF, 16'd0, 20'd10, 16'd4);
      send_item(ACT_RUN, 16'd0, 16'd0, 20'd0, 16'd0);
      wait_idle();

      // ratio above one: every nonzero test fails; zero limit ranks nothing
      write_reg(CSR_MIN_AREA_RATIO, 17'd131071);
      send_item(ACT_LOAD_PREV, 16'd200, 16'd200, 20'd50, 16'd1);
      send_item(ACT_LOAD_CURR, 16'd200, 16'd200, 20'd50, 16'd2);
      send_item(ACT_RUN, 16'd0, 16'd0, 20'd0, 16'd0);
      wait_idle();
      write_reg(CSR_MIN_AREA_RATIO, 17'd65536);
      write_reg(CSR_MAX_DISTANCE, 17'd0);
      send_item(ACT_LOAD_PREV, 16'd200, 16'd200, 20'd50, 16'd1);
      send_item(ACT_LOAD_CURR, 16'd200, 16'd200, 20'd50, 16'd2);
      send_item(ACT_RUN, 16'd0, 16'd0, 20'd0, 16'd0);
      wait_idle();

      // full previous store, one load dropped, no current regions
      write_reg(CSR_MAX_DISTANCE, 17'd20);
      write_reg(CSR_NEIGHBOUR_COUNT, 17'd3);
      write_reg(CSR_MIN_AREA_RATIO, 17'd8192);
      for (int i = 0; i <= MAX_REGIONS; i++)
         send_item(ACT_LOAD_PREV, 16'(i * 64), 16'(i * 64), 20'(i + 1), 16'(i + 1));
      send_item(ACT_RUN, 16'd0, 16'd0, 20'd0, 16'd0);
      wait_idle();

      // full current store against a single previous region
      send_item(ACT_LOAD_PREV, 16'd1000, 16'd1000, 20'd400, 16'd1);
      for (int i = 0; i <= MAX_REGIONS; i++)
         send_item(ACT_LOAD_CURR, 16'(1000 + i * 8), 16'd1000, 20'(300 + i), 16'(i + 2));
      send_item(ACT_RUN, 16'd0, 16'd0, 20'd0, 16'd0);
      wait_idle();

      // random part: sessions of well-formed loads and a run, settings changed while idle
      while (items_sent < ITEM_TARGET) begin
         if ($urandom_range(0, 2) == 0) begin
            wait_idle();
            random_config();
         end
         random_session();
      end

      wait_idle();
      repeat (50) @(posedge clock);
      $display("summary: %0d items sent over %0d runs, %0d result items compared",
               items_sent, runs_seen, results_checked);
      if (error_count == 0 && outstanding == 0) begin
         $display("knn_region_association_top_tb: clean");
      end else begin
         $display("knn_region_association_top_tb: errors");
      end
      $finish;
   end

endmodule
